[rtl/descriptor_slot_allocator_assert.svh]
// assertion macros for the descriptor slot allocator
// used by rtl/descriptor_slot_allocator.sv, no other dependencies
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dsa_pkg.sv]
// shared types and constants for the descriptor slot allocator
// no dependencies
package dsa_pkg;

  localparam int Depth       = 64;
  localparam int IdxW        = $clog2(Depth);
  localparam int HandleWidth = 32;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpGet    = 2'd1,
    OpRemove = 2'd2,
    OpMove   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StsOk       = 3'd0,
    StsBadIndex = 3'd1,
    StsFull     = 3'd2,
    StsSrcEmpty = 3'd3,
    StsDstBusy  = 3'd4
  } status_e;

  typedef struct packed {
    op_e         opcode;
    logic [7:0]  slot_index;
    logic [7:0]  target_index;
    logic [31:0] handle;
  } dsa_req_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  given_index;
    logic [31:0] read_handle;
  } dsa_rsp_t;

endpackage

[rtl/descriptor_slot_allocator.sv]
// a request is registered in StIdle; remove and requests rejected up front respond from StExec,
// get and move read the slot memory in StExec and respond from StRead; add scans up from the hint
// in StExec until a free slot or the last slot; the free-slot scan tests one slot per cycle
// one request at a time: in_ready_o returns as soon as the response is registered
// reset clears all occupancy flags and the hint at once; slot memory needs no clearing pass
// the slot memory is an array with one write port and one registered read port
module descriptor_slot_allocator
  import dsa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dsa_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dsa_rsp_t out_data_o
);

`include "descriptor_slot_allocator_assert.svh"

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StRead
  } state_e;

  state_e            state_q, state_d;
  dsa_req_t          item_q, item_d;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic [IdxW-1:0]   hint_q, hint_d;
  logic [Depth-1:0]  occ_q, occ_d;
  logic              out_valid_q, out_valid_d;
  dsa_rsp_t          out_q, out_d;

  logic [HandleWidth-1:0] mem [Depth];
  logic [HandleWidth-1:0] rdata_q;
  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  logic [HandleWidth-1:0] mem_wdata;

  logic            out_free;
  logic            src_ok, dst_ok;
  logic [IdxW-1:0] src_idx, dst_idx;
  logic [IdxW-1:0] hint_rel;
  logic [Depth-1:0] below_hint;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign src_ok   = 32'(item_q.slot_index) < Depth;
  assign dst_ok   = 32'(item_q.target_index) < Depth;
  assign src_idx  = item_q.slot_index[IdxW-1:0];
  assign dst_idx  = item_q.target_index[IdxW-1:0];
  // hint after releasing the source slot
  assign hint_rel = (src_idx < hint_q) ? src_idx : hint_q;

  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      below_hint[j] = j < int'(hint_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    scan_d      = scan_q;
    hint_d      = hint_q;
    occ_d       = occ_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = scan_q;
    mem_wdata   = HandleWidth'(item_q.handle);

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          scan_d  = hint_q;
          state_d = StExec;
        end
      end
      StExec: begin
        case (item_q.opcode)
          OpAdd: begin
            if (!occ_q[scan_q]) begin
              if (out_free) begin
                mem_we         = 1'b1;
                occ_d[scan_q]  = |item_q.handle;
                hint_d         = scan_q;
                out_d          = '{status: StsOk, given_index: 8'(scan_q), read_handle: '0};
                out_valid_d    = 1'b1;
                state_d        = StIdle;
              end
            end else if (scan_q == IdxW'(Depth - 1)) begin
              if (out_free) begin
                out_d       = '{status: StsFull, given_index: '0, read_handle: '0};
                out_valid_d = 1'b1;
                state_d     = StIdle;
              end
            end else begin
              scan_d = scan_q + 1'b1;
            end
          end
          OpGet: begin
            if (!src_ok) begin
              if (out_free) begin
                out_d       = '{status: StsBadIndex, given_index: '0, read_handle: '0};
                out_valid_d = 1'b1;
                state_d     = StIdle;
              end
            end else begin
              state_d = StRead;
            end
          end
          OpRemove: begin
            if (out_free) begin
              if (!src_ok) begin
                out_d = '{status: StsBadIndex, given_index: '0, read_handle: '0};
              end else begin
                occ_d[src_idx] = 1'b0;
                hint_d         = hint_rel;
                out_d          = '{status: StsOk, given_index: '0, read_handle: '0};
              end
              out_valid_d = 1'b1;
              state_d     = StIdle;
            end
          end
          default: begin
            if (!src_ok || !dst_ok || !occ_q[src_idx] || occ_q[dst_idx]) begin
              if (out_free) begin
                if (!src_ok || !dst_ok) begin
                  out_d = '{status: StsBadIndex, given_index: '0, read_handle: '0};
                end else if (!occ_q[src_idx]) begin
                  out_d = '{status: StsSrcEmpty, given_index: '0, read_handle: '0};
                end else begin
                  out_d = '{status: StsDstBusy, given_index: '0, read_handle: '0};
                end
                out_valid_d = 1'b1;
                state_d     = StIdle;
              end
            end else begin
              state_d = StRead;
            end
          end
        endcase
      end
      StRead: begin
        if (out_free) begin
          if (item_q.opcode == OpGet) begin
            out_d = '{status: StsOk, given_index: '0,
                      read_handle: occ_q[src_idx] ? 32'(rdata_q) : '0};
          end else begin
            // move: copy source data into the free target, then release the source
            mem_we         = 1'b1;
            mem_waddr      = dst_idx;
            mem_wdata      = rdata_q;
            occ_d[dst_idx] = 1'b1;
            occ_d[src_idx] = 1'b0;
            hint_d         = hint_rel;
            out_d          = '{status: StsOk, given_index: '0, read_handle: '0};
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_q      <= '0;
      hint_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      hint_q      <= hint_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  // slot memory, entries are meaningful only where the occupancy flag is set
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[src_idx];
  end

  `DSA_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o,
    state_q != StIdle, "accepted transaction did not start")
  `DSA_ASSERT_IMPL(a_hint_below_free, clk_i, rst_ni, 1'b1,
    (occ_q & below_hint) == below_hint, "free slot found below search hint")
  `DSA_ASSERT_IMPL(a_full_fields_zero, clk_i, rst_ni, out_valid_q && out_q.status == StsFull,
    out_q.given_index == '0 && out_q.read_handle == '0, "full response carries data")
  `DSA_ASSERT_NEXT(a_stalled_rsp_kept, clk_i, rst_ni, out_valid_q && !out_ready_i,
    out_valid_q && $stable(out_q), "stalled response lost")

endmodule

[tb/slot_allocator_checker.sv]
`timescale 1ns / 100ps
// response checker for the descriptor slot allocator: watches both channels,
// keeps its own slot table and search hint, and compares responses in order
// depends on rtl/dsa_pkg.sv
module slot_allocator_checker
  import dsa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  dsa_req_t in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  dsa_rsp_t out_data_i,
  output int       mismatch_count_o,
  output int       outstanding_o
);

  logic [HandleWidth-1:0] slot_mem [Depth];
  logic [IdxW-1:0]        free_hint;
  dsa_rsp_t               awaited_rsp_q [$];
  dsa_rsp_t               want;

  // clearing a slot pulls the hint down so it never passes a free slot
  function automatic void release_slot(input logic [7:0] idx);
    slot_mem[idx[IdxW-1:0]] = '0;
    if (idx < free_hint) begin
      free_hint = idx[IdxW-1:0];
    end
  endfunction

  function automatic dsa_rsp_t predict_response(input dsa_req_t req);
    dsa_rsp_t rsp;
    logic     found;
    int       pick;
    rsp.status      = StsOk;
    rsp.given_index = '0;
    rsp.read_handle = '0;
    found = 1'b0;
    pick  = 0;
    case (req.opcode)
      OpAdd: begin
        for (int s = int'(free_hint); s < Depth; s++) begin
          if (!found && slot_mem[s] == '0) begin
            found = 1'b1;
            pick  = s;
          end
        end
        // a null handle still claims the index and moves the hint, slot stays empty
        if (found) begin
          free_hint       = pick[IdxW-1:0];
          slot_mem[pick]  = req.handle;
          rsp.given_index = 8'(pick);
        end else begin
          rsp.status = StsFull;
        end
      end
      OpGet: begin
        if (req.slot_index >= Depth) begin
          rsp.status = StsBadIndex;
        end else begin
          rsp.read_handle = slot_mem[req.slot_index[IdxW-1:0]];
        end
      end
      OpRemove: begin
        if (req.slot_index >= Depth) begin
          rsp.status = StsBadIndex;
        end else begin
          release_slot(req.slot_index);
        end
      end
      default: begin
        if (req.slot_index >= Depth || req.target_index >= Depth) begin
          rsp.status = StsBadIndex;
        end else if (slot_mem[req.slot_index[IdxW-1:0]] == '0) begin
          rsp.status = StsSrcEmpty;
        end else if (slot_mem[req.target_index[IdxW-1:0]] != '0) begin
          rsp.status = StsDstBusy;
        end else begin
          slot_mem[req.target_index[IdxW-1:0]] = slot_mem[req.slot_index[IdxW-1:0]];
          release_slot(req.slot_index);
        end
      end
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        slot_mem[i] = '0;
      end
      free_hint = '0;
      awaited_rsp_q.delete();
      mismatch_count_o = 0;
      outstanding_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_rsp_q.size() == 0) begin
          $error("response transaction with no request outstanding");
          mismatch_count_o++;
        end else begin
          want = awaited_rsp_q.pop_front();
          if (out_data_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data_i.status);
            mismatch_count_o++;
          end
          if (out_data_i.given_index !== want.given_index) begin
            $error("given_index: expected %0d, actual %0d",
                   want.given_index, out_data_i.given_index);
            mismatch_count_o++;
          end
          if (out_data_i.read_handle !== want.read_handle) begin
            $error("read_handle: expected %h, actual %h",
                   want.read_handle, out_data_i.read_handle);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_rsp_q.push_back(predict_response(in_data_i));
      end
      outstanding_o = awaited_rsp_q.size();
    end
  end

endmodule

[tb/tb_descriptor_slot_allocator.sv]
`timescale 1ns / 100ps
// top of the descriptor slot allocator testbench: clock, reset, request stimulus,
// response back-pressure and the verdict; depends on rtl/dsa_pkg.sv, the block
// and tb/slot_allocator_checker.sv
module tb_descriptor_slot_allocator;
  import dsa_pkg::*;

  typedef enum int {FillPhase, MixedPhase, DrainPhase} phase_e;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  dsa_req_t in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dsa_rsp_t out_data;
  logic     calm      = 1'b0;
  int       mismatch_count;
  int       outstanding;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  descriptor_slot_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  slot_allocator_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // receiver stalls with a probability of about 12 percent, never during the calm stretch
  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 12);
  end

  function automatic dsa_req_t req_of(input op_e op, input logic [7:0] src,
                                      input logic [7:0] dst, input logic [31:0] h);
    dsa_req_t req;
    req.opcode       = op;
    req.slot_index   = src;
    req.target_index = dst;
    req.handle       = h;
    return req;
  endfunction

  // mostly in range, sometimes past the end of the table
  function automatic logic [7:0] pick_index();
    if ($urandom_range(99) < 15) begin
      return 8'($urandom_range(255, Depth));
    end
    return 8'($urandom_range(Depth - 1));
  endfunction

  function automatic dsa_req_t random_request(input phase_e phase);
    dsa_req_t req;
    int       roll;
    int       add_top;
    int       get_top;
    int       rm_top;
    case (phase)
      FillPhase: begin
        add_top = 65; get_top = 80; rm_top = 90;
      end
      DrainPhase: begin
        add_top = 15; get_top = 35; rm_top = 75;
      end
      default: begin
        add_top = 25; get_top = 50; rm_top = 75;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < add_top) begin
      req.opcode = OpAdd;
    end else if (roll < get_top) begin
      req.opcode = OpGet;
    end else if (roll < rm_top) begin
      req.opcode = OpRemove;
    end else begin
      req.opcode = OpMove;
    end
    req.slot_index   = pick_index();
    req.target_index = pick_index();
    roll = $urandom_range(99);
    if (roll < 5) begin
      req.handle = '0;
    end else if (roll < 10) begin
      req.handle = '1;
    end else begin
      req.handle = $urandom;
    end
    return req;
  endfunction

  task automatic send_request(input dsa_req_t req);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(req_of(OpGet,    8'd0,   8'd0,   32'h0000_0000));
    send_request(req_of(OpAdd,    8'd0,   8'd0,   32'hFFFF_FFFF));
    // null handle: index handed out but slot left free
    send_request(req_of(OpAdd,    8'hFF,  8'hFF,  32'h0000_0000));
    send_request(req_of(OpAdd,    8'd0,   8'd0,   32'h0000_0001));
    send_request(req_of(OpAdd,    8'd0,   8'd0,   32'hA5A5_5A5A));
    send_request(req_of(OpGet,    8'd0,   8'd0,   32'h0000_0000));
    send_request(req_of(OpGet,    8'd63,  8'd0,   32'h0000_0000));
    send_request(req_of(OpGet,    8'd64,  8'd0,   32'h0000_0000));
    send_request(req_of(OpGet,    8'd255, 8'd0,   32'h0000_0000));
    send_request(req_of(OpRemove, 8'd255, 8'd0,   32'h0000_0000));
    send_request(req_of(OpRemove, 8'd40,  8'd0,   32'h0000_0000));
    send_request(req_of(OpRemove, 8'd1,   8'd0,   32'h0000_0000));
    send_request(req_of(OpMove,   8'd0,   8'd200, 32'h0000_0000));
    send_request(req_of(OpMove,   8'd128, 8'd5,   32'h0000_0000));
    send_request(req_of(OpMove,   8'd10,  8'd11,  32'h0000_0000));
    send_request(req_of(OpMove,   8'd0,   8'd2,   32'h0000_0000));
    // same slot both ways: occupied then empty
    send_request(req_of(OpMove,   8'd0,   8'd0,   32'h0000_0000));
    send_request(req_of(OpMove,   8'd7,   8'd7,   32'h0000_0000));
    send_request(req_of(OpMove,   8'd0,   8'd63,  32'h0000_0000));
    send_request(req_of(OpGet,    8'd63,  8'd0,   32'h0000_0000));
    send_request(req_of(OpAdd,    8'd0,   8'd0,   32'h8000_0000));
    send_request(req_of(OpAdd,    8'hFF,  8'hFF,  32'h7FFF_FFFF));
    send_request(req_of(OpRemove, 8'd63,  8'd0,   32'h0000_0000));
    send_request(req_of(OpGet,    8'd0,   8'd0,   32'h0000_0000));

    // fill, mix and drain in turn so full-table and sparse cases both recur
    for (int k = 0; k < 10; k++) begin
      calm <= (k == 4);
      for (int n = 0; n < 110; n++) begin
        send_request(random_request(phase_e'(k % 3)));
      end
    end

    in_valid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) begin
      @(negedge clk_i);
    end
    repeat (80) @(negedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // generous bound on the whole run
  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
